// ===== hdl/mcq_pkg.sv =====
// Shared constants, types and register codes for the Morton code quantizer.
package mcq_pkg;

  localparam int QUANT_BITS = 10;
  localparam int NAXES      = 3;
  localparam int CW         = 32;
  localparam int DW         = CW + 1;
  localparam int RW         = DW + QUANT_BITS;
  localparam int CODE_W     = NAXES * QUANT_BITS;
  localparam int IDX_W      = 3;
  localparam int ADDR_W     = IDX_W + 2;

  localparam logic [QUANT_BITS-1:0] QMAX = {QUANT_BITS{1'b1}};
  localparam logic [CW-1:0] EXT_RESET = CW'(65536);

  typedef enum logic [IDX_W-1:0] {
    REG_MIN_X = 3'd0,
    REG_MIN_Y = 3'd1,
    REG_MIN_Z = 3'd2,
    REG_EXT_X = 3'd3,
    REG_EXT_Y = 3'd4,
    REG_EXT_Z = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [NAXES-1:0][CW-1:0] mn;
    logic [NAXES-1:0][CW-1:0] ext;
  } cfg_t;

  typedef struct packed {
    logic [RW-1:0]         rem;
    logic [CW-1:0]         ext;
    logic [QUANT_BITS-1:0] quo;
    logic                  sat;
    logic                  kill;
    logic                  clamp;
  } axis_t;

  typedef struct packed {
    logic                   valid;
    axis_t [NAXES-1:0]      ax;
  } item_t;

endpackage

// ===== hdl/mcq_prep.sv =====
// Front stages: offset, magnitude, scale by the quantizer range and range checks.
module mcq_prep (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_valid_i,
  output logic                                     in_rdy_o,
  input  logic [mcq_pkg::NAXES-1:0][mcq_pkg::CW-1:0] p_i,
  input  mcq_pkg::cfg_t                            cfg_i,
  output mcq_pkg::item_t                           dn_o,
  input  logic                                     dn_rdy_i
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic rdy1, rdy2, rdy3, rdy4;

  logic [mcq_pkg::DW-1:0] d1_r   [mcq_pkg::NAXES];
  logic [mcq_pkg::CW-1:0] ext1_r [mcq_pkg::NAXES];
  logic [mcq_pkg::DW-1:0] mag2_r [mcq_pkg::NAXES];
  logic                   neg2_r [mcq_pkg::NAXES];
  logic [mcq_pkg::CW-1:0] ext2_r [mcq_pkg::NAXES];
  logic [mcq_pkg::RW-1:0] n3_r   [mcq_pkg::NAXES];
  logic                   neg3_r [mcq_pkg::NAXES];
  logic [mcq_pkg::CW-1:0] ext3_r [mcq_pkg::NAXES];
  mcq_pkg::axis_t         ax4_r  [mcq_pkg::NAXES];

  logic [mcq_pkg::DW-1:0] d1_nxt   [mcq_pkg::NAXES];
  logic [mcq_pkg::DW-1:0] mag2_nxt [mcq_pkg::NAXES];
  logic [mcq_pkg::RW-1:0] n3_nxt   [mcq_pkg::NAXES];
  mcq_pkg::axis_t         ax4_nxt  [mcq_pkg::NAXES];

  assign rdy4     = !v4_r || dn_rdy_i;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_rdy_o = rdy1;

  always_comb begin
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      d1_nxt[a] = {p_i[a][mcq_pkg::CW-1], p_i[a]}
                - {cfg_i.mn[a][mcq_pkg::CW-1], cfg_i.mn[a]};
      mag2_nxt[a] = d1_r[a][mcq_pkg::DW-1] ? (~d1_r[a] + 1'b1) : d1_r[a];
      n3_nxt[a] = (mcq_pkg::RW'(mag2_r[a]) << mcq_pkg::QUANT_BITS)
                - mcq_pkg::RW'(mag2_r[a]);
      ax4_nxt[a].rem  = n3_r[a];
      ax4_nxt[a].ext  = ext3_r[a];
      ax4_nxt[a].quo  = '0;
      ax4_nxt[a].kill = (ext3_r[a] == '0) || neg3_r[a];
      ax4_nxt[a].sat  = (ext3_r[a] != '0) && !neg3_r[a]
                      && (n3_r[a] >= (mcq_pkg::RW'(ext3_r[a]) << mcq_pkg::QUANT_BITS));
      ax4_nxt[a].clamp = (ext3_r[a] != '0)
                       && (neg3_r[a] ? (n3_r[a] >= mcq_pkg::RW'(ext3_r[a]))
                                     : (n3_r[a] >= (mcq_pkg::RW'(ext3_r[a])
                                                    << mcq_pkg::QUANT_BITS)));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid_i;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      if (rdy1 && in_valid_i) begin
        d1_r[a]   <= d1_nxt[a];
        ext1_r[a] <= cfg_i.ext[a];
      end
      if (rdy2 && v1_r) begin
        mag2_r[a] <= mag2_nxt[a];
        neg2_r[a] <= d1_r[a][mcq_pkg::DW-1];
        ext2_r[a] <= ext1_r[a];
      end
      if (rdy3 && v2_r) begin
        n3_r[a]   <= n3_nxt[a];
        neg3_r[a] <= neg2_r[a];
        ext3_r[a] <= ext2_r[a];
      end
      if (rdy4 && v3_r) begin
        ax4_r[a] <= ax4_nxt[a];
      end
    end
  end

  always_comb begin
    dn_o.valid = v4_r;
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      dn_o.ax[a] = ax4_r[a];
    end
  end

`ifndef SYNTHESIS
  generate
    for (genvar a = 0; a < mcq_pkg::NAXES; a++) begin : g_chk
      a_kill_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        v4_r && ax4_r[a].kill |-> !ax4_r[a].sat)
        else $error("axis forced to zero and saturated at once");
    end
  endgenerate
`endif

endmodule

// ===== hdl/mcq_cell.sv =====
// Divider cell: one restoring quotient bit for each axis, with its own item register.
module mcq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  mcq_pkg::item_t up_i,
  output logic           up_rdy_o,
  output mcq_pkg::item_t dn_o,
  input  logic           dn_rdy_i
);

  logic           valid_r;
  mcq_pkg::axis_t ax_r  [mcq_pkg::NAXES];
  mcq_pkg::axis_t ax_nxt[mcq_pkg::NAXES];
  logic [mcq_pkg::RW-1:0] dsh [mcq_pkg::NAXES];
  logic                   ge  [mcq_pkg::NAXES];

  assign up_rdy_o = !valid_r || dn_rdy_i;

  always_comb begin
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      dsh[a]        = mcq_pkg::RW'(up_i.ax[a].ext) << (mcq_pkg::QUANT_BITS - 1);
      ge[a]         = up_i.ax[a].rem >= dsh[a];
      ax_nxt[a]     = up_i.ax[a];
      ax_nxt[a].rem = (ge[a] ? (up_i.ax[a].rem - dsh[a]) : up_i.ax[a].rem) << 1;
      ax_nxt[a].quo = (up_i.ax[a].quo << 1) | mcq_pkg::QUANT_BITS'(ge[a]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_rdy_o) begin
      valid_r <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o && up_i.valid) begin
      for (int a = 0; a < mcq_pkg::NAXES; a++) begin
        ax_r[a] <= ax_nxt[a];
      end
    end
  end

  always_comb begin
    dn_o.valid = valid_r;
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      dn_o.ax[a] = ax_r[a];
    end
  end

`ifndef SYNTHESIS
  generate
    for (genvar a = 0; a < mcq_pkg::NAXES; a++) begin : g_chk
      a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_r && !ax_r[a].sat && !ax_r[a].kill
        |-> ax_r[a].rem < (mcq_pkg::RW'(ax_r[a].ext) << mcq_pkg::QUANT_BITS))
        else $error("partial remainder out of range");
    end
  endgenerate
`endif

endmodule

// ===== hdl/mcq_pack.sv =====
// Output stage: zero or saturate axes, interleave into the Morton code, hold the result.
module mcq_pack (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mcq_pkg::item_t              up_i,
  output logic                        up_rdy_o,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [mcq_pkg::CODE_W-1:0]  code_o,
  output logic                        clamped_o
);

  logic                          valid_r;
  logic [mcq_pkg::CODE_W-1:0]    code_r;
  logic                          clamped_r;
  logic [mcq_pkg::CODE_W-1:0]    code_nxt;
  logic                          clamped_nxt;
  logic [mcq_pkg::QUANT_BITS-1:0] q [mcq_pkg::NAXES];

  assign up_rdy_o = !valid_r || !out_stall_i;

  always_comb begin
    clamped_nxt = 1'b0;
    for (int a = 0; a < mcq_pkg::NAXES; a++) begin
      if (up_i.ax[a].kill) begin
        q[a] = '0;
      end else if (up_i.ax[a].sat) begin
        q[a] = mcq_pkg::QMAX;
      end else begin
        q[a] = up_i.ax[a].quo;
      end
      clamped_nxt = clamped_nxt | up_i.ax[a].clamp;
    end
    for (int i = 0; i < mcq_pkg::QUANT_BITS; i++) begin
      for (int a = 0; a < mcq_pkg::NAXES; a++) begin
        code_nxt[mcq_pkg::NAXES*i + (mcq_pkg::NAXES-1-a)] = q[a][i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_rdy_o) begin
      valid_r <= up_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_rdy_o && up_i.valid) begin
      code_r    <= code_nxt;
      clamped_r <= clamped_nxt;
    end
  end

  assign out_valid_o = valid_r;
  assign code_o      = code_r;
  assign clamped_o   = clamped_r;

`ifndef SYNTHESIS
  a_sat_sets_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    up_rdy_o && up_i.valid && (up_i.ax[0].sat || up_i.ax[1].sat || up_i.ax[2].sat)
    |=> clamped_r)
    else $error("saturated axis without clamp flag");
`endif

endmodule

// ===== hdl/morton_code_3d_quantizer.sv =====
// Top level of the 3D Morton code quantizer: registers, front stages, divider chain, output.
//
// Usage: a point (in_px, in_py, in_pz, signed Q15.16) enters when in_valid is high and
// in_stall low. Each axis is offset by its scene minimum, scaled by 1023 and divided by
// its scene extent; the three 10-bit values are interleaved into out_code, with
// out_clamped set when an axis quotient fell outside 0..1023; a zero extent yields 0.
// Pipeline: a result passes four front stages, ten divider cells of one quotient bit each
// and one output register before it shows on out_valid.
// Throughput: one point per cycle while out_stall is low; every stage holds its own item and
// hands it on each cycle, so the divider chain sets the latency and not the rate.
// Stall: when out_stall holds a result, the stages behind it keep filling their empty
// slots; in_stall rises only once every stage holds an item.
// Reset (rst_n low at a clock edge) empties all stages, zeroes the minimums and sets the
// extents to 1.0. Registers are written over the APB port at byte address 4*index; the
// user must write them only while no item is in flight, which the block does not enforce.
module morton_code_3d_quantizer (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [mcq_pkg::CW-1:0]     in_px,
  input  logic signed [mcq_pkg::CW-1:0]     in_py,
  input  logic signed [mcq_pkg::CW-1:0]     in_pz,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [mcq_pkg::CODE_W-1:0]        out_code,
  output logic                              out_clamped,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [mcq_pkg::ADDR_W-1:0]        paddr,
  input  logic [mcq_pkg::CW-1:0]            pwdata,
  output logic [mcq_pkg::CW-1:0]            prdata,
  output logic                              pready
);

  mcq_pkg::cfg_t     cfg_r;
  mcq_pkg::reg_idx_t idx;
  logic              wr_en;
  logic              in_rdy;
  logic [mcq_pkg::NAXES-1:0][mcq_pkg::CW-1:0] pt;

  mcq_pkg::item_t chain [mcq_pkg::QUANT_BITS+1];
  logic           rdy   [mcq_pkg::QUANT_BITS+1];

  assign pready = 1'b1;
  assign idx    = mcq_pkg::reg_idx_t'(paddr[mcq_pkg::ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < mcq_pkg::NAXES; a++) begin
        cfg_r.mn[a]  <= '0;
        cfg_r.ext[a] <= mcq_pkg::EXT_RESET;
      end
    end else if (wr_en) begin
      unique case (idx)
        mcq_pkg::REG_MIN_X: cfg_r.mn[0]  <= pwdata;
        mcq_pkg::REG_MIN_Y: cfg_r.mn[1]  <= pwdata;
        mcq_pkg::REG_MIN_Z: cfg_r.mn[2]  <= pwdata;
        mcq_pkg::REG_EXT_X: cfg_r.ext[0] <= pwdata;
        mcq_pkg::REG_EXT_Y: cfg_r.ext[1] <= pwdata;
        mcq_pkg::REG_EXT_Z: cfg_r.ext[2] <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      mcq_pkg::REG_MIN_X: prdata = cfg_r.mn[0];
      mcq_pkg::REG_MIN_Y: prdata = cfg_r.mn[1];
      mcq_pkg::REG_MIN_Z: prdata = cfg_r.mn[2];
      mcq_pkg::REG_EXT_X: prdata = cfg_r.ext[0];
      mcq_pkg::REG_EXT_Y: prdata = cfg_r.ext[1];
      mcq_pkg::REG_EXT_Z: prdata = cfg_r.ext[2];
      default:            prdata = '0;
    endcase
  end

  assign pt[0]    = in_px;
  assign pt[1]    = in_py;
  assign pt[2]    = in_pz;
  assign in_stall = !in_rdy;

  mcq_prep u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_rdy_o   (in_rdy),
    .p_i        (pt),
    .cfg_i      (cfg_r),
    .dn_o       (chain[0]),
    .dn_rdy_i   (rdy[0])
  );

  generate
    for (genvar k = 0; k < mcq_pkg::QUANT_BITS; k++) begin : g_cell
      mcq_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_i     (chain[k]),
        .up_rdy_o (rdy[k]),
        .dn_o     (chain[k+1]),
        .dn_rdy_i (rdy[k+1])
      );
    end
  endgenerate

  mcq_pack u_pack (
    .clk         (clk),
    .rst_n       (rst_n),
    .up_i        (chain[mcq_pkg::QUANT_BITS]),
    .up_rdy_o    (rdy[mcq_pkg::QUANT_BITS]),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .code_o      (out_code),
    .clamped_o   (out_clamped)
  );

`ifndef SYNTHESIS
  a_empty_out_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input held off while the output register is empty");
`endif

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the 3D Morton code quantizer: queued driver, monitor, scoreboard.
`timescale 1ns / 1ps

module testbench;

  localparam logic [mcq_pkg::IDX_W-1:0] UNMAPPED_LO = 3'd6;
  localparam logic [mcq_pkg::IDX_W-1:0] UNMAPPED_HI = 3'd7;

  typedef struct {
    logic signed [mcq_pkg::CW-1:0] x;
    logic signed [mcq_pkg::CW-1:0] y;
    logic signed [mcq_pkg::CW-1:0] z;
  } point_t;

  typedef struct {
    logic [mcq_pkg::CODE_W-1:0] code;
    logic                       clamped;
  } morton_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic signed [mcq_pkg::CW-1:0]     in_px = '0;
  logic signed [mcq_pkg::CW-1:0]     in_py = '0;
  logic signed [mcq_pkg::CW-1:0]     in_pz = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [mcq_pkg::CODE_W-1:0]        out_code;
  logic                              out_clamped;
  logic                              psel = 1'b0;
  logic                              penable = 1'b0;
  logic                              pwrite = 1'b0;
  logic [mcq_pkg::ADDR_W-1:0]        paddr = '0;
  logic [mcq_pkg::CW-1:0]            pwdata = '0;
  logic [mcq_pkg::CW-1:0]            prdata;
  logic                              pready;

  logic signed [mcq_pkg::CW-1:0]     scene_min [mcq_pkg::NAXES];
  logic [mcq_pkg::CW-1:0]            scene_ext [mcq_pkg::NAXES];

  point_t                   pending_points [$];
  morton_t                  expected_codes [$];
  int                       errors = 0;
  int                       burst_left = 0;
  int                       gap_left = 0;
  int                       stall_mode = 0;
  int                       mode_left = 0;

  morton_code_3d_quantizer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_px       (in_px),
    .in_py       (in_py),
    .in_pz       (in_pz),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_code    (out_code),
    .out_clamped (out_clamped),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("morton_code_3d_quantizer: mismatch");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  // {clamp, axis value}
  function automatic logic [mcq_pkg::QUANT_BITS:0] quantize_axis(
      input logic signed [mcq_pkg::CW-1:0] p,
      input logic signed [mcq_pkg::CW-1:0] mn,
      input logic [mcq_pkg::CW-1:0] ext);
    longint diff;
    longint mag;
    longint q;
    diff = longint'(p) - longint'(mn);
    mag = (diff < 0) ? -diff : diff;
    if (ext == '0) return '0;
    q = (mag * longint'(mcq_pkg::QMAX)) / longint'(ext);
    if (diff < 0) return {(q != 0), {mcq_pkg::QUANT_BITS{1'b0}}};
    if (q > longint'(mcq_pkg::QMAX)) return {1'b1, mcq_pkg::QMAX};
    return {1'b0, q[mcq_pkg::QUANT_BITS-1:0]};
  endfunction

  function automatic morton_t predict_morton(input logic signed [mcq_pkg::CW-1:0] px,
                                             input logic signed [mcq_pkg::CW-1:0] py,
                                             input logic signed [mcq_pkg::CW-1:0] pz);
    logic [mcq_pkg::QUANT_BITS:0] qx;
    logic [mcq_pkg::QUANT_BITS:0] qy;
    logic [mcq_pkg::QUANT_BITS:0] qz;
    morton_t r;
    qx = quantize_axis(px, scene_min[0], scene_ext[0]);
    qy = quantize_axis(py, scene_min[1], scene_ext[1]);
    qz = quantize_axis(pz, scene_min[2], scene_ext[2]);
    r.code = '0;
    for (int i = 0; i < mcq_pkg::QUANT_BITS; i++) begin
      r.code[3*i+2] = qx[i];
      r.code[3*i+1] = qy[i];
      r.code[3*i]   = qz[i];
    end
    r.clamped = qx[mcq_pkg::QUANT_BITS] | qy[mcq_pkg::QUANT_BITS] | qz[mcq_pkg::QUANT_BITS];
    return r;
  endfunction

  function automatic logic [mcq_pkg::CW-1:0] scene_reg(input mcq_pkg::reg_idx_t r);
    case (r)
      mcq_pkg::REG_MIN_X: return scene_min[0];
      mcq_pkg::REG_MIN_Y: return scene_min[1];
      mcq_pkg::REG_MIN_Z: return scene_min[2];
      mcq_pkg::REG_EXT_X: return scene_ext[0];
      mcq_pkg::REG_EXT_Y: return scene_ext[1];
      mcq_pkg::REG_EXT_Z: return scene_ext[2];
      default: return '0;
    endcase
  endfunction

  task automatic apb_access(input logic wr, input logic [mcq_pkg::IDX_W-1:0] idx,
                            input logic [mcq_pkg::CW-1:0] data,
                            output logic [mcq_pkg::CW-1:0] rdata);
    logic done;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do begin
      @(negedge clk);
      rdata = prdata;
      done = pready;
      @(posedge clk);
    end while (!done);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic write_reg(input logic [mcq_pkg::IDX_W-1:0] idx,
                           input logic [mcq_pkg::CW-1:0] data);
    logic [mcq_pkg::CW-1:0] unused;
    apb_access(1'b1, idx, data, unused);
    case (mcq_pkg::reg_idx_t'(idx))
      mcq_pkg::REG_MIN_X: scene_min[0] = data;
      mcq_pkg::REG_MIN_Y: scene_min[1] = data;
      mcq_pkg::REG_MIN_Z: scene_min[2] = data;
      mcq_pkg::REG_EXT_X: scene_ext[0] = data;
      mcq_pkg::REG_EXT_Y: scene_ext[1] = data;
      mcq_pkg::REG_EXT_Z: scene_ext[2] = data;
      default: ;
    endcase
  endtask

  task automatic set_scene(input logic [mcq_pkg::CW-1:0] mx, input logic [mcq_pkg::CW-1:0] my,
                           input logic [mcq_pkg::CW-1:0] mz, input logic [mcq_pkg::CW-1:0] ex,
                           input logic [mcq_pkg::CW-1:0] ey, input logic [mcq_pkg::CW-1:0] ez);
    write_reg(mcq_pkg::REG_MIN_X, mx);
    write_reg(mcq_pkg::REG_MIN_Y, my);
    write_reg(mcq_pkg::REG_MIN_Z, mz);
    write_reg(mcq_pkg::REG_EXT_X, ex);
    write_reg(mcq_pkg::REG_EXT_Y, ey);
    write_reg(mcq_pkg::REG_EXT_Z, ez);
  endtask

  task automatic check_scene();
    logic [mcq_pkg::CW-1:0] rdata;
    mcq_pkg::reg_idx_t r;
    for (int i = mcq_pkg::REG_MIN_X; i <= mcq_pkg::REG_EXT_Z; i++) begin
      r = mcq_pkg::reg_idx_t'(i);
      apb_access(1'b0, r, '0, rdata);
      if (rdata !== scene_reg(r))
        report_mismatch($sformatf("register %s read %h, expected %h", r.name(), rdata,
                                  scene_reg(r)));
    end
  endtask

  task automatic add_point(input logic [mcq_pkg::CW-1:0] x, input logic [mcq_pkg::CW-1:0] y,
                           input logic [mcq_pkg::CW-1:0] z);
    point_t p;
    p.x = x;
    p.y = y;
    p.z = z;
    pending_points.push_back(p);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_points.size() != 0 || in_valid || expected_codes.size() != 0);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [mcq_pkg::CW-1:0] rand_extent();
    case ($urandom_range(0, 9))
      0, 1: return $urandom_range(1, 255);
      2, 3, 4: return $urandom_range(32'h10000, 32'h1000000);
      5, 6: return $urandom;
      7: return 32'hFFFF_FFFF;
      8: return $urandom_range(1, 4);
      default: return ($urandom_range(0, 1) == 0) ? '0 : $urandom_range(256, 65535);
    endcase
  endfunction

  function automatic logic signed [mcq_pkg::CW-1:0] scene_coord(
      input logic signed [mcq_pkg::CW-1:0] mn,
      input logic [mcq_pkg::CW-1:0] ext);
    int unsigned pick;
    longint span;
    longint off;
    pick = $urandom_range(0, 19);
    span = longint'(ext) + 1;
    if (pick < 15) begin
      off = longint'($urandom) % span;
    end else if (pick < 17) begin
      off = -(longint'($urandom_range(1, 64)) + longint'(ext) / 512 * $urandom_range(0, 1));
    end else if (pick < 19) begin
      off = span + longint'($urandom_range(0, 64)) + longint'(ext) / 512 * $urandom_range(0, 1);
    end else begin
      case ($urandom_range(0, 3))
        0: return 32'sh7FFF_FFFF;
        1: return 32'sh8000_0000;
        default: return $urandom;
      endcase
    end
    return mcq_pkg::CW'(longint'(mn) + off);
  endfunction

  task automatic add_scene_points(input int n);
    for (int i = 0; i < n; i++)
      add_point(scene_coord(scene_min[0], scene_ext[0]), scene_coord(scene_min[1], scene_ext[1]),
                scene_coord(scene_min[2], scene_ext[2]));
  endtask

  always @(posedge clk) begin : feed
    point_t pt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid) expected_codes.push_back(predict_morton(in_px, in_py, in_pz));
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_points.size() > 0) begin
        pt = pending_points.pop_front();
        in_px <= pt.x;
        in_py <= pt.y;
        in_pz <= pt.z;
        in_valid <= 1'b1;
        if (burst_left == 0) burst_left = $urandom_range(1, 32);
        burst_left--;
        if (burst_left == 0 && $urandom_range(0, 2) != 0)
          gap_left = $urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : watch
    morton_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_mode = 0;
      mode_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_codes.size() == 0) begin
          report_mismatch($sformatf("unexpected item code=%h clamped=%b", out_code, out_clamped));
        end else begin
          want = expected_codes.pop_front();
          if (out_code !== want.code || out_clamped !== want.clamped)
            report_mismatch($sformatf("expected code=%h clamped=%b, got code=%h clamped=%b",
                                      want.code, want.clamped, out_code, out_clamped));
        end
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 9) < 3);
        2: out_stall <= ($urandom_range(0, 9) < 8);
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  initial begin
    scene_min = '{default: '0};
    scene_ext = '{default: mcq_pkg::EXT_RESET};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    check_scene();
    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h10000, 32'h10000, 32'h10000);
    add_point(32'hFFFF, 32'h8000, 32'h1);
    add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_point(32'hFFFF_0000, 32'h0, 32'h0);
    add_point(32'h7FFF_FFFF, 32'h0, 32'h0);
    add_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h20000, 32'h40, 32'hFFFF_FFC0);
    add_scene_points(50);
    wait_drained();

    set_scene(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    check_scene();
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
    add_point(32'h0, 32'h7FFF_FFFF, 32'h8000_0000);
    add_point(32'h8000_0000, 32'h0, 32'h7FFF_FFFF);
    add_scene_points(30);
    wait_drained();

    set_scene(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h1, 32'h1, 32'h1);
    check_scene();
    add_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFE);
    add_point(32'h8000_0000, 32'h7FFF_FFFE, 32'h7FFF_FFFF);
    add_point(32'h7FFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000);
    add_scene_points(20);
    wait_drained();

    set_scene($urandom, $urandom, $urandom, 32'h0, 32'h0010_0000, 32'h0);
    write_reg(UNMAPPED_LO, 32'hFFFF_FFFF);
    write_reg(UNMAPPED_HI, 32'h0);
    check_scene();
    add_scene_points(30);
    wait_drained();

    for (int ph = 0; ph < 8; ph++) begin
      set_scene($urandom, $urandom, $urandom, rand_extent(), rand_extent(), rand_extent());
      check_scene();
      add_scene_points(140);
      wait_drained();
    end

    if (errors == 0) begin
      $display("morton_code_3d_quantizer: match");
    end else begin
      $display("morton_code_3d_quantizer: mismatch");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/mcq_pkg.sv
hdl/mcq_prep.sv
hdl/mcq_cell.sv
hdl/mcq_pack.sv
hdl/morton_code_3d_quantizer.sv
tb/testbench.sv
